### rtl/bounded_integer_set_engine_top_assert.svh
// Assertion macros for the bounded integer set engine.
// Used by bounded_integer_set_engine_top; expects aclk and aresetn in scope.
`ifndef BOUNDED_INTEGER_SET_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_INTEGER_SET_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BISE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define BISE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BISE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BISE_ASSERT_ALWAYS(lbl, expr, msg)
`define BISE_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BISE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/bise_pkg.sv
// Shared types and constants of the bounded integer set engine.
// No dependencies.
`default_nettype none
package bise_pkg;
    localparam int SET_CAPACITY = 32;
    localparam int IDX_W        = $clog2(SET_CAPACITY);
    localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
    localparam int ELEM_W       = 32;

    typedef enum logic [2:0] {
        ACT_INSERT  = 3'd0,
        ACT_DELETE  = 3'd1,
        ACT_QUERY   = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_UNION   = 3'd4,
        ACT_ISECT   = 3'd5,
        ACT_DIFF    = 3'd6,
        ACT_SYMDIFF = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SRCH_DONE,
        S_SHF_RD,
        S_SHF_WR,
        S_RESP,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_CHK,
        S_OUT_EMIT,
        S_PHASE_END,
        S_FINAL
    } state_t;
endpackage
`default_nettype wire

### rtl/bounded_integer_set_engine_top.sv
// Bounded integer set engine: two insertion-ordered sets in RAM, one comparator.
// Insert, delete and query scan the target set entry by entry before the result word is
// registered; delete then moves each later entry down one place. Clear, and insert into a
// full set, skip the scan. Set operations scan the other set once per filtered element,
// with a second pass over B for union and symmetric difference.
// Throughput: one word at a time, s_tready high only when idle. Reset empties both sets.
`default_nettype none
`include "bounded_integer_set_engine_top_assert.svh"
module bounded_integer_set_engine_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [3:0]  s_tuser,   // [2:0] action, [3] which_set
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] element, [32] is_member, [35:33] status, pad
    output logic             m_tlast
);
    localparam int IW = bise_pkg::IDX_W;
    localparam int CW = bise_pkg::CNT_W;
    localparam logic [CW-1:0] CAP = CW'(bise_pkg::SET_CAPACITY);

    // Set storage
    logic [31:0] mem_a [bise_pkg::SET_CAPACITY];
    logic [31:0] mem_b [bise_pkg::SET_CAPACITY];
    logic [31:0] rd_a_reg, rd_b_reg;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [31:0] wr_data;
    logic wr_en_a, wr_en_b;

    bise_pkg::state_t state_reg, state_next;
    bise_pkg::action_t act_reg, act_next;
    logic tgt_reg, tgt_next;
    logic srch_set_reg, srch_set_next;
    logic phase_reg, phase_next;
    logic found_reg, found_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] val_reg, val_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] i_inc;
    bise_pkg::status_t rstat_reg, rstat_next;
    logic rmem_reg, rmem_next;
    logic pend_v_reg, pend_v_next;
    logic [31:0] pend_reg, pend_next;

    logic m_valid_reg, m_mem_reg, m_last_reg;
    logic [31:0] m_elem_reg;
    bise_pkg::status_t m_stat_reg;

    logic can_push, push, p_mem, p_last;
    logic [31:0] p_elem;
    bise_pkg::status_t p_stat;

    logic [CW-1:0] srch_cnt, src_cnt, tgt_cnt;
    logic [31:0] srch_q, src_q;
    logic filt, want_in, two_phase;

    assign i_inc    = i_reg + CW'(1);
    assign srch_cnt = srch_set_reg ? cnt_b_reg : cnt_a_reg;
    assign src_cnt  = phase_reg ? cnt_b_reg : cnt_a_reg;
    assign tgt_cnt  = tgt_reg ? cnt_b_reg : cnt_a_reg;
    assign srch_q   = srch_set_reg ? rd_b_reg : rd_a_reg;
    assign src_q    = phase_reg ? rd_b_reg : rd_a_reg;
    assign can_push = !m_valid_reg || m_tready;
    assign two_phase = (act_reg == bise_pkg::ACT_UNION) || (act_reg == bise_pkg::ACT_SYMDIFF);
    assign filt     = !((act_reg == bise_pkg::ACT_UNION) && !phase_reg);
    assign want_in  = (act_reg == bise_pkg::ACT_ISECT);

    // Write and read the set memories
    always_ff @(posedge aclk) begin
        if (wr_en_a) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr_en_b) begin
            mem_b[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_a[rd_addr];
        rd_b_reg <= mem_b[rd_addr];
    end

    // Sequencer register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bise_pkg::S_IDLE;
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            pend_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            pend_v_reg <= pend_v_next;
        end
        act_reg      <= act_next;
        tgt_reg      <= tgt_next;
        srch_set_reg <= srch_set_next;
        phase_reg    <= phase_next;
        found_reg    <= found_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        rstat_reg    <= rstat_next;
        rmem_reg     <= rmem_next;
        pend_reg     <= pend_next;
    end

    // Next state and datapath control
    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        tgt_next      = tgt_reg;
        srch_set_next = srch_set_reg;
        phase_next    = phase_reg;
        found_next    = found_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rstat_next    = rstat_reg;
        rmem_next     = rmem_reg;
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        rd_addr       = i_reg[IW-1:0];
        wr_addr       = i_reg[IW-1:0];
        wr_data       = key_reg;
        wr_en_a       = 1'b0;
        wr_en_b       = 1'b0;
        push          = 1'b0;
        p_elem        = val_reg;
        p_mem         = 1'b0;
        p_stat        = bise_pkg::ST_OK;
        p_last        = 1'b1;
        s_tready      = 1'b0;
        case (state_reg)
            bise_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    act_next   = bise_pkg::action_t'(s_tuser[2:0]);
                    tgt_next   = s_tuser[3];
                    val_next   = s_tdata;
                    key_next   = s_tdata;
                    state_next = bise_pkg::S_DISPATCH;
                end
            end
            bise_pkg::S_DISPATCH: begin
                rmem_next     = 1'b0;
                rstat_next    = bise_pkg::ST_OK;
                srch_set_next = tgt_reg;
                j_next        = '0;
                found_next    = 1'b0;
                case (act_reg)
                    bise_pkg::ACT_INSERT: begin
                        if (tgt_cnt >= CAP) begin
                            rstat_next = bise_pkg::ST_FULL;
                            state_next = bise_pkg::S_RESP;
                        end else begin
                            state_next = bise_pkg::S_SRCH_RD;
                        end
                    end
                    bise_pkg::ACT_DELETE, bise_pkg::ACT_QUERY: begin
                        state_next = bise_pkg::S_SRCH_RD;
                    end
                    bise_pkg::ACT_CLEAR: begin
                        if (tgt_reg) begin
                            cnt_b_next = '0;
                        end else begin
                            cnt_a_next = '0;
                        end
                        state_next = bise_pkg::S_RESP;
                    end
                    default: begin
                        phase_next  = 1'b0;
                        i_next      = '0;
                        pend_v_next = 1'b0;
                        state_next  = bise_pkg::S_OUT_RD;
                    end
                endcase
            end
            // Scan the searched set for key, one entry at a time
            bise_pkg::S_SRCH_RD: begin
                rd_addr = j_reg[IW-1:0];
                if (j_reg >= srch_cnt) begin
                    found_next = 1'b0;
                    state_next = bise_pkg::S_SRCH_DONE;
                end else begin
                    state_next = bise_pkg::S_SRCH_CMP;
                end
            end
            bise_pkg::S_SRCH_CMP: begin
                if (srch_q == key_reg) begin
                    found_next = 1'b1;
                    state_next = bise_pkg::S_SRCH_DONE;
                end else begin
                    j_next     = j_reg + CW'(1);
                    state_next = bise_pkg::S_SRCH_RD;
                end
            end
            bise_pkg::S_SRCH_DONE: begin
                case (act_reg)
                    bise_pkg::ACT_INSERT: begin
                        if (found_reg) begin
                            rstat_next = bise_pkg::ST_DUP;
                        end else begin
                            wr_addr = tgt_cnt[IW-1:0];
                            wr_data = val_reg;
                            if (tgt_reg) begin
                                wr_en_b    = 1'b1;
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end else begin
                                wr_en_a    = 1'b1;
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end
                        end
                        state_next = bise_pkg::S_RESP;
                    end
                    bise_pkg::ACT_DELETE: begin
                        if (found_reg) begin
                            i_next     = j_reg;
                            state_next = bise_pkg::S_SHF_RD;
                        end else begin
                            rstat_next = bise_pkg::ST_NOT_FOUND;
                            state_next = bise_pkg::S_RESP;
                        end
                    end
                    bise_pkg::ACT_QUERY: begin
                        rmem_next  = found_reg;
                        state_next = bise_pkg::S_RESP;
                    end
                    default: begin
                        state_next = bise_pkg::S_OUT_CHK;
                    end
                endcase
            end
            // Close the gap left by a deleted entry
            bise_pkg::S_SHF_RD: begin
                rd_addr = i_inc[IW-1:0];
                if (i_inc >= srch_cnt) begin
                    if (srch_set_reg) begin
                        cnt_b_next = cnt_b_reg - CW'(1);
                    end else begin
                        cnt_a_next = cnt_a_reg - CW'(1);
                    end
                    state_next = bise_pkg::S_RESP;
                end else begin
                    state_next = bise_pkg::S_SHF_WR;
                end
            end
            bise_pkg::S_SHF_WR: begin
                wr_data    = srch_q;
                wr_en_a    = !srch_set_reg;
                wr_en_b    = srch_set_reg;
                i_next     = i_inc;
                state_next = bise_pkg::S_SHF_RD;
            end
            // Hand over the single result word
            bise_pkg::S_RESP: begin
                p_mem  = rmem_reg;
                p_stat = rstat_reg;
                if (can_push) begin
                    push       = 1'b1;
                    state_next = bise_pkg::S_IDLE;
                end
            end
            // Walk the source set of the current pass
            bise_pkg::S_OUT_RD: begin
                if (i_reg >= src_cnt) begin
                    state_next = bise_pkg::S_PHASE_END;
                end else begin
                    state_next = bise_pkg::S_OUT_LD;
                end
            end
            bise_pkg::S_OUT_LD: begin
                key_next = src_q;
                if (filt) begin
                    srch_set_next = !phase_reg;
                    j_next        = '0;
                    state_next    = bise_pkg::S_SRCH_RD;
                end else begin
                    state_next = bise_pkg::S_OUT_EMIT;
                end
            end
            bise_pkg::S_OUT_CHK: begin
                if (found_reg == want_in) begin
                    state_next = bise_pkg::S_OUT_EMIT;
                end else begin
                    i_next     = i_inc;
                    state_next = bise_pkg::S_OUT_RD;
                end
            end
            // Hold one element back so the final one can carry last
            bise_pkg::S_OUT_EMIT: begin
                p_elem = pend_reg;
                p_last = 1'b0;
                if (!pend_v_reg || can_push) begin
                    push        = pend_v_reg;
                    pend_next   = key_reg;
                    pend_v_next = 1'b1;
                    i_next      = i_inc;
                    state_next  = bise_pkg::S_OUT_RD;
                end
            end
            bise_pkg::S_PHASE_END: begin
                if (!phase_reg && two_phase) begin
                    phase_next = 1'b1;
                    i_next     = '0;
                    state_next = bise_pkg::S_OUT_RD;
                end else begin
                    state_next = bise_pkg::S_FINAL;
                end
            end
            bise_pkg::S_FINAL: begin
                p_elem = pend_v_reg ? pend_reg : '0;
                p_stat = pend_v_reg ? bise_pkg::ST_OK : bise_pkg::ST_EMPTY;
                if (can_push) begin
                    push        = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = bise_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bise_pkg::S_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (push) begin
            m_elem_reg <= p_elem;
            m_mem_reg  <= p_mem;
            m_stat_reg <= p_stat;
            m_last_reg <= p_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_stat_reg, m_mem_reg, m_elem_reg};
    assign m_tlast  = m_last_reg;

    `BISE_ASSERT_ALWAYS(a_cnt_bound, (cnt_a_reg <= CAP) && (cnt_b_reg <= CAP), "set count over capacity")
    `BISE_ASSERT_IMPLY(a_empty_word, m_valid_reg && (m_stat_reg == bise_pkg::ST_EMPTY), m_last_reg && (m_elem_reg == 32'd0), "empty result word malformed")
    `BISE_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "took a second word while busy")
    `BISE_ASSERT_IMPLY(a_member_only_query, m_valid_reg && m_mem_reg, m_last_reg && (m_stat_reg == bise_pkg::ST_OK), "membership flag on non-query word")
endmodule
`default_nettype wire

### tb/sv/bounded_integer_set_engine_top_tb.sv
// Testbench for bounded_integer_set_engine_top: directed and random set actions
// checked against an in-bench model of both sets. Depends on rtl/bise_pkg.sv and the RTL.
`timescale 1ns / 1ps
module bounded_integer_set_engine_top_tb;

    localparam int STALL_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 24;

    typedef struct {
        logic [31:0]        element;
        logic               is_member;
        bise_pkg::status_t  status;
        logic               last;
    } set_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] value
    logic [3:0]  s_tuser = '0;   // [2:0] action, [3] which_set
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [31:0] element, [32] is_member, [35:33] status, pad
    logic        m_tlast;

    // Model copy of both sets: index 0 is A, 1 is B
    logic [31:0] set_words [2][bise_pkg::SET_CAPACITY];
    int          set_size [2];

    set_result_t pending_results[$];
    logic [31:0] value_pool[16];
    bit          idle_on = 1'b1;
    bit          rx_hold = 1'b0;
    int          mismatches = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          stall_cycles = 0;

    bounded_integer_set_engine_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic bit set_holds(int s, logic [31:0] v);
        for (int i = 0; i < set_size[s]; i++) begin
            if (set_words[s][i] == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_result(logic [31:0] e, logic mem, bise_pkg::status_t st);
        set_result_t r;
        r.element = e;
        r.is_member = mem;
        r.status = st;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Stream every element of src that passes the filter against the other set
    function automatic int stream_filtered(int src, bit filt, bit want_in);
        int n;
        n = 0;
        for (int i = 0; i < set_size[src]; i++) begin
            if (!filt || set_holds(1 - src, set_words[src][i]) == want_in) begin
                add_result(set_words[src][i], 1'b0, bise_pkg::ST_OK);
                n++;
            end
        end
        return n;
    endfunction

    // Update the set copy and queue the results one accepted word causes
    function automatic void apply_action(bise_pkg::action_t act, int s, logic [31:0] v);
        int n;
        int pos;
        n = 0;
        case (act)
            bise_pkg::ACT_INSERT: begin
                if (set_size[s] >= bise_pkg::SET_CAPACITY) begin
                    add_result(v, 1'b0, bise_pkg::ST_FULL);
                end else if (set_holds(s, v)) begin
                    add_result(v, 1'b0, bise_pkg::ST_DUP);
                end else begin
                    set_words[s][set_size[s]] = v;
                    set_size[s]++;
                    add_result(v, 1'b0, bise_pkg::ST_OK);
                end
                n = 1;
            end
            bise_pkg::ACT_DELETE: begin
                pos = -1;
                for (int i = 0; i < set_size[s]; i++) begin
                    if (pos < 0 && set_words[s][i] == v) pos = i;
                end
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < set_size[s]; i++) begin
                        set_words[s][i] = set_words[s][i + 1];
                    end
                    set_size[s]--;
                    add_result(v, 1'b0, bise_pkg::ST_OK);
                end else begin
                    add_result(v, 1'b0, bise_pkg::ST_NOT_FOUND);
                end
                n = 1;
            end
            bise_pkg::ACT_QUERY: begin
                add_result(v, set_holds(s, v), bise_pkg::ST_OK);
                n = 1;
            end
            bise_pkg::ACT_CLEAR: begin
                set_size[s] = 0;
                add_result(v, 1'b0, bise_pkg::ST_OK);
                n = 1;
            end
            bise_pkg::ACT_UNION: begin
                n = stream_filtered(0, 1'b0, 1'b0);
                n += stream_filtered(1, 1'b1, 1'b0);
            end
            bise_pkg::ACT_ISECT: n = stream_filtered(0, 1'b1, 1'b1);
            bise_pkg::ACT_DIFF:  n = stream_filtered(0, 1'b1, 1'b0);
            default: begin
                n = stream_filtered(0, 1'b1, 1'b0);
                n += stream_filtered(1, 1'b1, 1'b0);
            end
        endcase
        if (n == 0) begin
            add_result('0, 1'b0, bise_pkg::ST_EMPTY);
        end
        pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // Offer one word after a random gap; predict at the accepting edge
    task automatic send_word(bise_pkg::action_t act, bit which, logic [31:0] v);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {which, act};
        s_tdata <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_action(act, which, v);
        words_in++;
    endtask

    // Stop offering and wait until every expected result has come
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stalls per word, plus an optional long hold
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0 || rx_hold) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                while (rx_hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            words_out++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: data=%h last=%b", m_tdata, m_tlast);
            end else begin
                set_result_t r;
                r = pending_results.pop_front();
                if (m_tdata[31:0] !== r.element || m_tdata[32] !== r.is_member ||
                    m_tdata[35:33] !== r.status || m_tlast !== r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b/%0d/%b got %h/%b/%0d/%b",
                                 r.element, r.is_member, r.status, r.last,
                                 m_tdata[31:0], m_tdata[32], m_tdata[35:33], m_tlast);
                end
            end
        end
    end

    // Watchdog on cycles with no word accepted on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Extremes, duplicates, delete with gap closing, query, clear, empty results
    task automatic test_basic_actions();
        send_word(bise_pkg::ACT_UNION, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_ISECT, 1'b1, 32'hFFFF_FFFF);
        send_word(bise_pkg::ACT_INSERT, 1'b0, 32'h8000_0000);
        send_word(bise_pkg::ACT_INSERT, 1'b0, 32'h7FFF_FFFF);
        send_word(bise_pkg::ACT_INSERT, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_INSERT, 1'b0, 32'hFFFF_FFFF);
        send_word(bise_pkg::ACT_INSERT, 1'b0, 32'h7FFF_FFFF);
        send_word(bise_pkg::ACT_QUERY, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_QUERY, 1'b1, 32'h0);
        send_word(bise_pkg::ACT_DELETE, 1'b0, 32'h7FFF_FFFF);
        send_word(bise_pkg::ACT_DELETE, 1'b0, 32'h1234_5678);
        send_word(bise_pkg::ACT_INSERT, 1'b1, 32'h0);
        send_word(bise_pkg::ACT_INSERT, 1'b1, 32'h5A5A_A5A5);
        send_word(bise_pkg::ACT_UNION, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_ISECT, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_DIFF, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_SYMDIFF, 1'b1, 32'h0);
        send_word(bise_pkg::ACT_CLEAR, 1'b0, 32'hDEAD_BEEF);
        send_word(bise_pkg::ACT_DELETE, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_DIFF, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_CLEAR, 1'b1, 32'h0);
        wait_drained();
    endtask

    // Fill both sets disjointly; full beats duplicate; largest union
    task automatic test_full_sets();
        for (int i = 0; i < bise_pkg::SET_CAPACITY; i++)
            send_word(bise_pkg::ACT_INSERT, 1'b0, 32'h1000 + i);
        for (int i = 0; i < bise_pkg::SET_CAPACITY; i++)
            send_word(bise_pkg::ACT_INSERT, 1'b1, 32'hF000_0000 + i);
        send_word(bise_pkg::ACT_INSERT, 1'b0, 32'h1000);
        send_word(bise_pkg::ACT_INSERT, 1'b1, 32'h0BAD_0BAD);
        send_word(bise_pkg::ACT_UNION, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_SYMDIFF, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_ISECT, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_DELETE, 1'b0, 32'h1000);
        send_word(bise_pkg::ACT_DELETE, 1'b0, 32'h1000 + bise_pkg::SET_CAPACITY - 1);
        send_word(bise_pkg::ACT_INSERT, 1'b1, 32'h1005);
        send_word(bise_pkg::ACT_DIFF, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_CLEAR, 1'b0, 32'h0);
        send_word(bise_pkg::ACT_CLEAR, 1'b1, 32'h0);
        wait_drained();
    endtask

    // Hold the receiver off while queries keep coming, so the input stalls
    task automatic test_output_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (600) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 8; i++) send_word(bise_pkg::ACT_QUERY, i[0], $urandom);
        wait_drained();
    endtask

    // Random actions over a small value pool so hits and misses both occur
    task automatic test_random_actions();
        int pick;
        logic [31:0] v;
        bise_pkg::action_t act;
        for (int i = 0; i < 16; i++) value_pool[i] = $urandom;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 8 == 0) idle_on = (n != 8);
            pick = $urandom_range(0, 99);
            if (pick < 40)      act = bise_pkg::ACT_INSERT;
            else if (pick < 55) act = bise_pkg::ACT_DELETE;
            else if (pick < 68) act = bise_pkg::ACT_QUERY;
            else if (pick < 71) act = bise_pkg::ACT_CLEAR;
            else                act = bise_pkg::action_t'(3'(4 + $urandom_range(0, 3)));
            v = ($urandom_range(0, 9) < 8) ? value_pool[$urandom_range(0, 15)] : $urandom;
            send_word(act, $urandom_range(0, 1), v);
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_actions();
        test_full_sets();
        test_output_backpressure();
        test_random_actions();
        $display("Sent %0d action words and checked %0d result words across insert, delete,",
                 words_in, words_out);
        $display("query, clear, full sets and all four set operations under random stalls.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/bise_pkg.sv
rtl/bounded_integer_set_engine_top.sv
tb/sv/bounded_integer_set_engine_top_tb.sv
